>>> rtl/core/rphl_pkg.sv
// ============================================================================
// rphl_pkg
// Shared types and constants for the resource pressure hysteresis level block.
// ============================================================================
package rphl_pkg;

  // Pressure level codes
  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_PRESSURE = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_t;

  // Register indexes on the configuration port
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned IDX_W    = 3;
  localparam logic [IDX_W-1:0] REG_INT_CRIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_INT_PRES = 3'd1;
  localparam logic [IDX_W-1:0] REG_EXT_CRIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_EXT_PRES = 3'd3;
  localparam logic [IDX_W-1:0] REG_STO_CRIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_STO_PRES = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_INT_CRIT = 32'd8192;
  localparam logic [31:0] RST_INT_PRES = 32'd16384;
  localparam logic [31:0] RST_EXT_CRIT = 32'd262144;
  localparam logic [31:0] RST_EXT_PRES = 32'd524288;
  localparam logic [31:0] RST_STO_CRIT = 32'd262144;
  localparam logic [31:0] RST_STO_PRES = 32'd1048576;

  // Fixed clear thresholds (leave critical, leave pressure)
  localparam logic [31:0] INT_CRIT_EXIT = 32'(12 * 1024);
  localparam logic [31:0] INT_PRES_EXIT = 32'(20 * 1024);
  localparam logic [31:0] EXT_CRIT_EXIT = 32'(384 * 1024);
  localparam logic [31:0] EXT_PRES_EXIT = 32'(768 * 1024);
  localparam logic [31:0] STO_CRIT_EXIT = 32'(384 * 1024);
  localparam logic [31:0] STO_PRES_EXIT = 32'(1280 * 1024);

  // Threshold set handed from the register file to the datapath
  typedef struct packed {
    logic [31:0] int_crit;
    logic [31:0] int_pres;
    logic [31:0] ext_crit;
    logic [31:0] ext_pres;
    logic [31:0] sto_crit;
    logic [31:0] sto_pres;
  } thresh_t;

endpackage

>>> rtl/core/rphl_cfg_regs.sv
// ============================================================================
// rphl_cfg_regs
// APB-style register file holding the six trigger thresholds.
// ============================================================================
module rphl_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output rphl_pkg::thresh_t thr
);
  import rphl_pkg::*;

  thresh_t          thr_r;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign thr        = thr_r;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.int_crit <= RST_INT_CRIT;
      thr_r.int_pres <= RST_INT_PRES;
      thr_r.ext_crit <= RST_EXT_CRIT;
      thr_r.ext_pres <= RST_EXT_PRES;
      thr_r.sto_crit <= RST_STO_CRIT;
      thr_r.sto_pres <= RST_STO_PRES;
    end else if (wr_en) begin
      unique case (idx)
        REG_INT_CRIT: thr_r.int_crit <= cfg_pwdata;
        REG_INT_PRES: thr_r.int_pres <= cfg_pwdata;
        REG_EXT_CRIT: thr_r.ext_crit <= cfg_pwdata;
        REG_EXT_PRES: thr_r.ext_pres <= cfg_pwdata;
        REG_STO_CRIT: thr_r.sto_crit <= cfg_pwdata;
        REG_STO_PRES: thr_r.sto_pres <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Return the addressed register on reads
  always_comb begin
    unique case (idx)
      REG_INT_CRIT: cfg_prdata = thr_r.int_crit;
      REG_INT_PRES: cfg_prdata = thr_r.int_pres;
      REG_EXT_CRIT: cfg_prdata = thr_r.ext_crit;
      REG_EXT_PRES: cfg_prdata = thr_r.ext_pres;
      REG_STO_CRIT: cfg_prdata = thr_r.sto_crit;
      REG_STO_PRES: cfg_prdata = thr_r.sto_pres;
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/rphl_core.sv
// ============================================================================
// rphl_core
// Input register, level update with hysteresis and admission check, result
// register.
// ============================================================================
module rphl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  rphl_pkg::thresh_t thr,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [191:0]      in_tdata,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata
);
  import rphl_pkg::*;

  // Input register
  logic         s1_valid_r;
  logic [191:0] s1_data_r;
  logic         s1_present_r;

  // Result register and level state
  logic         out_valid_r;
  level_t       out_level_r;
  logic         out_ok_r;
  logic         out_alloc_r;
  level_t       level_r;

  logic         out_load;
  logic         in_take;
  logic [31:0]  inf, exf, stf, inr, exr, str;
  logic         below_crit_exit, below_crit_reg, below_pres_exit, below_pres_reg;
  level_t       lvl_nxt;
  logic         alloc_nxt;

  assign out_load  = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | out_load;
  assign in_take   = in_tvalid & in_tready;

  assign inf = s1_data_r[31:0];
  assign exf = s1_data_r[63:32];
  assign stf = s1_data_r[95:64];
  assign inr = s1_data_r[127:96];
  assign exr = s1_data_r[159:128];
  assign str = s1_data_r[191:160];

  // Compare readings against clear and trigger thresholds
  assign below_crit_exit = (inf < INT_CRIT_EXIT) | (exf < EXT_CRIT_EXIT) |
                           (stf < STO_CRIT_EXIT);
  assign below_crit_reg  = (inf < thr.int_crit) | (exf < thr.ext_crit) |
                           (stf < thr.sto_crit);
  assign below_pres_exit = (inf < INT_PRES_EXIT) | (exf < EXT_PRES_EXIT) |
                           (stf < STO_PRES_EXIT);
  assign below_pres_reg  = (inf < thr.int_pres) | (exf < thr.ext_pres) |
                           (stf < thr.sto_pres);

  // Pick the next level; missing storage forces critical
  always_comb begin
    if (!s1_present_r) begin
      lvl_nxt = LVL_CRITICAL;
    end else if (level_r == LVL_CRITICAL && below_crit_exit) begin
      lvl_nxt = LVL_CRITICAL;
    end else if (below_crit_reg) begin
      lvl_nxt = LVL_CRITICAL;
    end else if (level_r == LVL_PRESSURE && below_pres_exit) begin
      lvl_nxt = LVL_PRESSURE;
    end else if (below_pres_reg) begin
      lvl_nxt = LVL_PRESSURE;
    end else begin
      lvl_nxt = LVL_NORMAL;
    end
  end

  // Admit the request only if each remainder keeps its pressure margin
  function automatic logic keeps_margin(logic [31:0] avail, logic [31:0] want,
                                        logic [31:0] margin);
    logic [31:0] rem;
    rem = avail - want;
    return (want <= avail) && (rem >= margin);
  endfunction

  assign alloc_nxt = (lvl_nxt == LVL_NORMAL) & s1_present_r &
                     keeps_margin(inf, inr, thr.int_pres) &
                     keeps_margin(exf, exr, thr.ext_pres) &
                     keeps_margin(stf, str, thr.sto_pres);

  // Capture an accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r    <= in_tdata;
      s1_present_r <= in_tuser;
    end
  end

  // Advance the level state and load the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= LVL_NORMAL;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        level_r     <= lvl_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r <= lvl_nxt;
      out_ok_r    <= (lvl_nxt != LVL_CRITICAL);
      out_alloc_r <= alloc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_alloc_r, out_ok_r, out_level_r};

  // Checks
  a_absent_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !s1_present_r |=> out_level_r == LVL_CRITICAL)
    else $error("absent storage did not force critical");

  a_alloc_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_alloc_r |-> out_level_r == LVL_NORMAL && out_ok_r)
    else $error("allocation granted outside normal level");

  a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> level_r == out_level_r)
    else $error("level state differs from delivered level");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room in the pipeline");

endmodule

>>> rtl/core/resource_pressure_hysteresis_level.sv
// ============================================================================
// resource_pressure_hysteresis_level
// Three-level resource pressure monitor with hysteresis and admission check.
// ============================================================================
// Each input transfer carries one sample of free internal, external and
// storage bytes, a storage-present flag and three requested byte counts. The
// block moves a pressure level (normal, pressure, critical) and returns one
// result transfer per sample: the new level, whether optional work may run,
// and whether the requested allocation is admitted: normal level, every margin kept.
// Each sample passes through two registers, the input register and then the
// result register. The block takes one sample per cycle unless the receiver
// stalls; the next level is computed combinationally from the level register.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more sample; then in_tready drops until the
// result is taken.
// Thresholds are to be written over the APB-style port only while the block
// is idle; the block does not enforce this. Reset (rst_n low, synchronous)
// empties both registers, sets normal level, restores default thresholds.
// ============================================================================
module resource_pressure_hysteresis_level (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // internal_free[31:0], external_free[63:32], storage_free[95:64],
  // internal_request[127:96], external_request[159:128],
  // storage_request[191:160]
  input  logic [191:0] in_tdata,
  // storage_present[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // level[1:0], optional_work_ok[2], allocation_ok[3], zero[7:4]
  output logic [7:0]   out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import rphl_pkg::*;

  thresh_t thr;

  rphl_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  rphl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/resource_pressure_hysteresis_level_test.sv
// ----------------------------------------------------------------------------
// resource_pressure_hysteresis_level_test
// Self-checking regression for the resource pressure hysteresis level block.
// Samples stream in over the input channel under random and forced stalls; a
// built-in predictor tracks the pressure level and thresholds, and every
// result transfer is compared field by field with the oldest prediction.
// Thresholds are written and read back over the APB-style port between phases.
// ----------------------------------------------------------------------------
module resource_pressure_hysteresis_level_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rphl_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int DUT_LATENCY    = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [31:0] inf;
    logic [31:0] exf;
    logic [31:0] stf;
    logic        present;
    logic [31:0] inr;
    logic [31:0] exr;
    logic [31:0] str;
  } sample_t;

  typedef struct packed {
    level_t level;
    logic   work_ok;
    logic   alloc_ok;
  } verdict_t;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata    = '0;
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [4:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Predictor state: thresholds and level as the block should hold them
  logic [31:0] thr_model [NUM_REGS];
  logic [31:0] thr_default [NUM_REGS];
  level_t      level_model = LVL_NORMAL;
  verdict_t    verdict_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_count   = 0;
  int stall_count = 0;
  logic rx_holding = 1'b0;
  event rx_hold_go;

  resource_pressure_hysteresis_level u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Toggle receiver readiness; a long hold-off overrides the random stalls
  always @(posedge clk) begin
    out_tready <= !rx_holding && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hold the receiver off for a fixed stretch when asked
  initial forever begin
    @(rx_hold_go);
    rx_holding <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_holding <= 1'b0;
  end

  // Record one mismatch; report only the first few
  task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("[%0t] mismatch %s: expected 0x%08h, actual 0x%08h",
                 $realtime, what, exp_val, act_val);
    end
  endtask

  // Compare each result transfer with the oldest prediction; watch for a hang.
  // Sampling on the falling edge keeps the check clear of the rising-edge update.
  always @(negedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (verdict_q.size() == 0) begin
        check_field("unexpected result", 32'h0, 32'(out_tdata));
        if (out_tdata == 8'h0) err_count++;
      end else begin
        v = verdict_q.pop_front();
        check_field("level", 32'(v.level), 32'(out_tdata[1:0]));
        check_field("optional_work_ok", 32'(v.work_ok), 32'(out_tdata[2]));
        check_field("allocation_ok", 32'(v.alloc_ok), 32'(out_tdata[3]));
        check_field("pad bits", 32'h0, 32'(out_tdata[7:4]));
      end
    end
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) || cfg_psel)
      stall_count = 0;
    else
      stall_count++;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("resource_pressure_hysteresis_level regression: fail");
      $finish;
    end
  end

  function automatic logic keeps_margin(logic [31:0] avail, logic [31:0] want,
                                        logic [31:0] margin);
    return (want <= avail) && ((avail - want) >= margin);
  endfunction

  // Send one sample, predict its result at the accepting edge
  task automatic send_sample(sample_t s);
    logic   rdy;
    level_t nxt;
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {s.str, s.exr, s.inr, s.stf, s.exf, s.inf};
    in_tuser  <= s.present;
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = (in_tready === 1'b1);
      @(posedge clk);
    end while (!rdy);
    // Hysteresis: leaving critical needs every reading at or above its clear level
    if (!s.present)
      nxt = LVL_CRITICAL;
    else if (level_model == LVL_CRITICAL &&
             (s.inf < INT_CRIT_EXIT || s.exf < EXT_CRIT_EXIT || s.stf < STO_CRIT_EXIT))
      nxt = LVL_CRITICAL;
    else if (s.inf < thr_model[REG_INT_CRIT] || s.exf < thr_model[REG_EXT_CRIT] ||
             s.stf < thr_model[REG_STO_CRIT])
      nxt = LVL_CRITICAL;
    else if (level_model == LVL_PRESSURE &&
             (s.inf < INT_PRES_EXIT || s.exf < EXT_PRES_EXIT || s.stf < STO_PRES_EXIT))
      nxt = LVL_PRESSURE;
    else if (s.inf < thr_model[REG_INT_PRES] || s.exf < thr_model[REG_EXT_PRES] ||
             s.stf < thr_model[REG_STO_PRES])
      nxt = LVL_PRESSURE;
    else
      nxt = LVL_NORMAL;
    level_model = nxt;
    v.level    = nxt;
    v.work_ok  = (nxt != LVL_CRITICAL);
    v.alloc_ok = (nxt == LVL_NORMAL) && s.present &&
                 keeps_margin(s.inf, s.inr, thr_model[REG_INT_PRES]) &&
                 keeps_margin(s.exf, s.exr, thr_model[REG_EXT_PRES]) &&
                 keeps_margin(s.stf, s.str, thr_model[REG_STO_PRES]);
    verdict_q.push_back(v);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access until pready
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [31:0] value);
    logic rdy;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = (cfg_pready === 1'b1);
      @(posedge clk);
    end while (!rdy);
    if (idx < NUM_REGS) thr_model[idx] = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read every threshold back and compare with the predictor's copy
  task automatic verify_registers();
    logic rdy;
    logic [31:0] data;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= {IDX_W'(i), 2'b00};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do begin
        @(negedge clk);
        rdy  = (cfg_pready === 1'b1);
        data = cfg_prdata;
        @(posedge clk);
      end while (!rdy);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      @(posedge clk);
      check_field($sformatf("register %0d readback", i), thr_model[i], data);
    end
  endtask

  task automatic set_thresholds(logic [31:0] t [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) cfg_write(IDX_W'(i), t[i]);
    verify_registers();
  endtask

  function automatic sample_t mk_sample(logic [31:0] inf, logic [31:0] exf,
                                        logic [31:0] stf, logic present,
                                        logic [31:0] inr, logic [31:0] exr,
                                        logic [31:0] str);
    sample_t s;
    s.inf = inf; s.exf = exf; s.stf = stf; s.present = present;
    s.inr = inr; s.exr = exr; s.str = str;
    return s;
  endfunction

  // Reading comfortably above both the trigger and the clear level
  function automatic logic [31:0] healthy_reading(logic [31:0] pres, logic [31:0] pexit);
    logic [31:0] hi;
    hi = (pres > pexit) ? pres : pexit;
    if (hi > 32'hFFFF_EFFF) hi = 32'hFFFF_EFFF;
    return hi + 32'($urandom_range(0, 4095));
  endfunction

  // Reading at an edge of the field, at random, or close to one of the four thresholds
  function automatic logic [31:0] pick_reading(logic [31:0] crit, logic [31:0] pres,
                                               logic [31:0] cexit, logic [31:0] pexit);
    int unsigned sel;
    logic [31:0] pivot;
    sel = $urandom_range(0, 11);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return $urandom;
    case ($urandom_range(0, 3))
      0: pivot = crit;
      1: pivot = pres;
      2: pivot = cexit;
      default: pivot = pexit;
    endcase
    return pivot + 32'($urandom_range(0, 6)) - 32'd3;
  endfunction

  // Request that mostly keeps the margin, sometimes sits on or past its edge
  function automatic logic [31:0] pick_request(logic [31:0] free, logic [31:0] margin);
    int unsigned sel;
    logic [63:0] room;
    sel = $urandom_range(0, 19);
    if (sel <= 8) begin
      if (free < margin) return 32'($urandom_range(0, 15));
      room = 64'(free - margin) + 64'd1;
      return 32'({$urandom, $urandom} % room);
    end
    if (sel <= 10) return free - margin;
    if (sel <= 12) return free - margin + 32'd1;
    if (sel == 13) return (free == 32'hFFFF_FFFF) ? free : free + 32'd1;
    if (sel == 14) return free;
    if (sel == 15) return 32'hFFFF_FFFF;
    if (sel == 16) return 32'h0;
    return $urandom;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.inf = ($urandom_range(0, 9) < 7) ?
            healthy_reading(thr_model[REG_INT_PRES], INT_PRES_EXIT) :
            pick_reading(thr_model[REG_INT_CRIT], thr_model[REG_INT_PRES],
                         INT_CRIT_EXIT, INT_PRES_EXIT);
    s.exf = ($urandom_range(0, 9) < 7) ?
            healthy_reading(thr_model[REG_EXT_PRES], EXT_PRES_EXIT) :
            pick_reading(thr_model[REG_EXT_CRIT], thr_model[REG_EXT_PRES],
                         EXT_CRIT_EXIT, EXT_PRES_EXIT);
    s.stf = ($urandom_range(0, 9) < 7) ?
            healthy_reading(thr_model[REG_STO_PRES], STO_PRES_EXIT) :
            pick_reading(thr_model[REG_STO_CRIT], thr_model[REG_STO_PRES],
                         STO_CRIT_EXIT, STO_PRES_EXIT);
    s.present = ($urandom_range(0, 99) >= 6);
    s.inr = pick_request(s.inf, thr_model[REG_INT_PRES]);
    s.exr = pick_request(s.exf, thr_model[REG_EXT_PRES]);
    s.str = pick_request(s.stf, thr_model[REG_STO_PRES]);
    return s;
  endfunction

  task automatic run_random(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_sample(random_sample());
  endtask

  function automatic logic [31:0] rand_threshold(logic [31:0] dflt);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return $urandom;
    return (dflt >> 1) + 32'($urandom_range(0, (dflt >> 1) * 3));
  endfunction

  // Write and read back every register; indexes past the last must be ignored
  task automatic test_register_access();
    logic [31:0] t [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) t[i] = $urandom;
    verify_registers();
    set_thresholds(t);
    cfg_write(IDX_W'(NUM_REGS), $urandom);
    cfg_write(IDX_W'(NUM_REGS + 1), $urandom);
    verify_registers();
    set_thresholds(thr_default);
  endtask

  // Walk the level through every transition but pressure to critical, with default thresholds
  task automatic test_directed_levels();
    logic [31:0] hi_in, hi_ex, hi_st, mx;
    hi_in = 32'd1048576;
    hi_ex = 32'd8388608;
    hi_st = 32'd67108864;
    mx    = 32'hFFFF_FFFF;
    tx_idle_pct = 21;
    rx_idle_pct = 70;
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(mx, mx, mx, 1'b1, mx, mx, mx));
    send_sample(mk_sample(mx, mx, mx, 1'b1, 0, 0, 0));
    send_sample(mk_sample(0, 0, 0, 1'b1, 0, 0, 0));
    // still critical while one reading stays under its clear level
    send_sample(mk_sample(INT_CRIT_EXIT - 1, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, EXT_CRIT_EXIT - 1, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, STO_CRIT_EXIT - 1, 1'b1, 0, 0, 0));
    // leave critical into pressure, then hold pressure below the clear level
    send_sample(mk_sample(INT_CRIT_EXIT, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(RST_INT_PRES, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(INT_PRES_EXIT - 1, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(INT_PRES_EXIT, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, RST_EXT_PRES - 1, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, EXT_PRES_EXIT, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, RST_STO_PRES - 1, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, STO_PRES_EXIT, 1'b1, 0, 0, 0));
    // straight from normal to critical and back
    send_sample(mk_sample(RST_INT_CRIT - 1, hi_ex, hi_st, 1'b1, 0, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, 0, 0));
    // missing storage forces critical whatever the readings
    send_sample(mk_sample(mx, mx, mx, 1'b0, 0, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, 0, 0));
    // admission margin exactly kept, then missed by one
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, hi_in - RST_INT_PRES, 0, 0));
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, hi_in - RST_INT_PRES + 1, 0, 0));
    // request above the free count never wraps
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, hi_ex + 1, 0));
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, 0, mx));
    send_sample(mk_sample(hi_in, hi_ex, hi_st, 1'b1, 0, 0, hi_st - RST_STO_PRES));
    send_sample(mk_sample(0, 0, 0, 1'b0, mx, mx, mx));
    wait_drained();
  endtask

  task automatic test_random_default();
    run_random(250, 21, 70);
    wait_drained();
  endtask

  // Several random threshold sets, each after a drained pipeline
  task automatic test_random_thresholds();
    logic [31:0] t [NUM_REGS];
    repeat (5) begin
      for (int i = 0; i < NUM_REGS; i++) t[i] = rand_threshold(thr_default[i]);
      set_thresholds(t);
      run_random(50, 70, 21);
      wait_drained();
    end
  endtask

  // Trigger thresholds written above the fixed clear levels
  task automatic test_clear_below_trigger();
    logic [31:0] t [NUM_REGS];
    t[REG_INT_CRIT] = 32'd16384;
    t[REG_INT_PRES] = 32'd32768;
    t[REG_EXT_CRIT] = 32'd524288;
    t[REG_EXT_PRES] = 32'd1048576;
    t[REG_STO_CRIT] = 32'd524288;
    t[REG_STO_PRES] = 32'd2097152;
    set_thresholds(t);
    run_random(150, 0, 0);
    wait_drained();
  endtask

  task automatic test_threshold_extremes();
    logic [31:0] t [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) t[i] = 32'h0;
    set_thresholds(t);
    run_random(50, 0, 0);
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) t[i] = 32'hFFFF_FFFF;
    set_thresholds(t);
    run_random(50, 0, 0);
    wait_drained();
  endtask

  // Fill the block while the receiver holds off, then let it drain
  task automatic test_backpressure();
    set_thresholds(thr_default);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> rx_hold_go;
    repeat (30) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    thr_default[REG_INT_CRIT] = RST_INT_CRIT;
    thr_default[REG_INT_PRES] = RST_INT_PRES;
    thr_default[REG_EXT_CRIT] = RST_EXT_CRIT;
    thr_default[REG_EXT_PRES] = RST_EXT_PRES;
    thr_default[REG_STO_CRIT] = RST_STO_CRIT;
    thr_default[REG_STO_PRES] = RST_STO_PRES;
    for (int i = 0; i < NUM_REGS; i++) thr_model[i] = thr_default[i];
    level_model = LVL_NORMAL;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_levels();
    test_random_default();
    test_random_thresholds();
    test_clear_below_trigger();
    test_threshold_extremes();
    test_backpressure();

    wait_drained();
    repeat (DUT_LATENCY * 4) @(posedge clk);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("resource_pressure_hysteresis_level regression: pass");
    end else begin
      $display("resource_pressure_hysteresis_level regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rphl_pkg.sv
rtl/core/rphl_cfg_regs.sv
rtl/core/rphl_core.sv
rtl/core/resource_pressure_hysteresis_level.sv
tb/resource_pressure_hysteresis_level_test.sv
